// ===== rtl/core/rmscm_pkg.sv =====
package rmscm_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 12;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int MUX_W  = 2;
  localparam int GAIN_W = 16;
  localparam int RMS_W  = 17;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(9900);

  // Datapath widths
  localparam int SUM_W     = 34;               // saturating square sum
  localparam int SHIFT_Q   = 17;               // factor 2 and Q16 scale of the mean square
  localparam int DIV_W     = SUM_W + SHIFT_Q;  // dividend and quotient
  localparam int RT_W      = (DIV_W + 1) / 2;  // Q8 root
  localparam int MP_W      = RT_W + GAIN_W;    // root times gain
  localparam int RMS_SHIFT = 20;
  localparam int P_W       = MP_W - RMS_SHIFT;
  localparam int STEP_W    = $clog2(DIV_W + 1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WINDOW  = 2'd2;

  // Result kinds
  localparam logic KIND_SETUP   = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  // Reading sequence
  localparam logic [2:0] LAST_INDEX = 3'd4;

endpackage

// ===== rtl/core/rmscm_in_if.sv =====
interface rmscm_in_if #(
  parameter int SAMPLE_BITS = rmscm_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [rmscm_pkg::CMD_W-1:0]   cmd;
  logic [SAMPLE_BITS-1:0]        sample_code;

  modport source (output valid, cmd, sample_code, input ready);
  modport sink   (input valid, cmd, sample_code, output ready);
endinterface

// ===== rtl/core/rmscm_out_if.sv =====
interface rmscm_out_if ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [rmscm_pkg::MUX_W-1:0]   mux_select;
  logic                          adc_channel;
  logic [rmscm_pkg::RMS_W-1:0]   rms_centiamps;
  logic                          overflow;

  modport source (output valid, kind, mux_select, adc_channel, rms_centiamps, overflow,
                  input ready);
  modport sink   (input valid, kind, mux_select, adc_channel, rms_centiamps, overflow,
                  output ready);
endinterface

// ===== rtl/core/rmscm_cfg_if.sv =====
interface rmscm_cfg_if ();
  logic                          valid;
  logic                          ready;
  logic [rmscm_pkg::GAIN_W-1:0]  gain_centiamps_fullscale;

  modport source (output valid, gain_centiamps_fullscale, input ready);
  modport sink   (input valid, gain_centiamps_fullscale, output ready);
endinterface

// ===== rtl/core/rms_current_meter_channel_rotation.sv =====
// Channel  Dir  Payload                                                  Transaction when
// in_ch    in   cmd, sample_code                                         valid && ready
// out_ch   out  kind, mux_select, adc_channel, rms_centiamps, overflow   valid && ready
// cfg_ch   in   gain_centiamps_fullscale                                 valid && ready
//
// Work per command: a request goes straight to the emit step; a sample runs the bit-serial
//   squarer, then one sum add; a window end runs the bit-serial divider, square root and
//   gain multiplier, one bit or one root digit per cycle; an empty window goes straight to emit.
// One transaction is in work at a time; in_ch.ready is high only when idle.
// The result register frees the input side: a result waiting on out_ch only holds a
//   later request or window end in its final emit cycle. cfg_ch is always ready.
// Reset (rst_n low, synchronous): index 0, select 0, channel 1, sum/count/flag clear,
//   gain 9900.
module rms_current_meter_channel_rotation #(
  parameter int MAX_SAMPLES = rmscm_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = rmscm_pkg::SAMPLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rmscm_in_if.sink          in_ch,
  rmscm_out_if.source       out_ch,
  rmscm_cfg_if.sink         cfg_ch
);
  import rmscm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W  = 2 * SAMPLE_BITS;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;  // shift-add square of the sample
  localparam logic [2:0] ST_ADD  = 3'd2;  // saturating add into the sum
  localparam logic [2:0] ST_DIV  = 3'd3;  // restoring divide by the count
  localparam logic [2:0] ST_SQRT = 3'd4;  // digit-by-digit square root
  localparam logic [2:0] ST_MUL  = 3'd5;  // shift-add root times gain
  localparam logic [2:0] ST_EMIT = 3'd6;  // load the result register

  logic [2:0]             state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;

  // Architectural state
  logic [GAIN_W-1:0]      gain_r, gain_nxt;
  logic [2:0]             index_r, index_nxt;
  logic [MUX_W-1:0]       mux_r, mux_nxt;
  logic                   chan_r, chan_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   dropped_r, dropped_nxt;

  // Datapath shift registers
  logic [SQ_W-1:0]        sq_mcand_r, sq_mcand_nxt;
  logic [SAMPLE_BITS-1:0] sq_mplier_r, sq_mplier_nxt;
  logic [SQ_W-1:0]        sq_acc_r, sq_acc_nxt;
  logic [DIV_W-1:0]       num_r, num_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [2*RT_W-1:0]      rad_r, rad_nxt;
  logic [RT_W+1:0]        srem_r, srem_nxt;
  logic [RT_W-1:0]        root_r, root_nxt;
  logic [MP_W-1:0]        mp_mcand_r, mp_mcand_nxt;
  logic [GAIN_W-1:0]      mp_mplier_r, mp_mplier_nxt;
  logic [MP_W-1:0]        mp_acc_r, mp_acc_nxt;
  logic                   kind_r, kind_nxt;

  // Result register
  logic                   ov_r, ov_nxt;
  logic                   o_kind_r, o_kind_nxt;
  logic [MUX_W-1:0]       o_mux_r, o_mux_nxt;
  logic                   o_chan_r, o_chan_nxt;
  logic [RMS_W-1:0]       o_rms_r, o_rms_nxt;
  logic                   o_ovf_r, o_ovf_nxt;

  // Step logic
  logic [SUM_W:0]         sum_ext;
  logic [CNT_W:0]         div_trial;
  logic [CNT_W:0]         div_diff;
  logic                   div_ge;
  logic [RT_W+3:0]        sq_trial;
  logic [RT_W+3:0]        sq_test;
  logic [RT_W+3:0]        sq_diff;
  logic                   sq_ge;
  logic [P_W-1:0]         prod_hi;
  logic [RMS_W-1:0]       rms_sat;
  logic                   in_fire;
  logic [2:0]             index_inc;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign index_inc = index_r + 3'd1;

  assign sum_ext   = {1'b0, sum_r} + (SUM_W + 1)'(sq_acc_r);
  assign div_trial = {rem_r, num_r[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, count_r};
  assign div_diff  = div_trial - {1'b0, count_r};
  assign sq_trial  = {srem_r, rad_r[2*RT_W-1 -: 2]};
  assign sq_test   = {2'b00, root_r, 2'b01};
  assign sq_ge     = sq_trial >= sq_test;
  assign sq_diff   = sq_trial - sq_test;
  assign prod_hi   = mp_acc_r[MP_W-1:RMS_SHIFT];
  assign rms_sat   = (|prod_hi[P_W-1:RMS_W]) ? {RMS_W{1'b1}} : prod_hi[RMS_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    gain_nxt      = gain_r;
    index_nxt     = index_r;
    mux_nxt       = mux_r;
    chan_nxt      = chan_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    sq_mcand_nxt  = sq_mcand_r;
    sq_mplier_nxt = sq_mplier_r;
    sq_acc_nxt    = sq_acc_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    rad_nxt       = rad_r;
    srem_nxt      = srem_r;
    root_nxt      = root_r;
    mp_mcand_nxt  = mp_mcand_r;
    mp_mplier_nxt = mp_mplier_r;
    mp_acc_nxt    = mp_acc_r;
    kind_nxt      = kind_r;
    ov_nxt        = ov_r;
    o_kind_nxt    = o_kind_r;
    o_mux_nxt     = o_mux_r;
    o_chan_nxt    = o_chan_r;
    o_rms_nxt     = o_rms_r;
    o_ovf_nxt     = o_ovf_r;

    if (cfg_ch.valid) begin
      gain_nxt = cfg_ch.gain_centiamps_fullscale;
    end

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.cmd)
            CMD_REQUEST: begin
              // steps one to four drive select 0..3 on channel 1; step five wraps
              if (index_inc <= LAST_INDEX) begin
                index_nxt = index_inc;
                mux_nxt   = MUX_W'(index_r);
                chan_nxt  = 1'b1;
              end else begin
                index_nxt = 3'd0;
                chan_nxt  = 1'b0;
              end
              sum_nxt     = '0;
              count_nxt   = '0;
              dropped_nxt = 1'b0;
              mp_acc_nxt  = '0;
              kind_nxt    = KIND_SETUP;
              state_nxt   = ST_EMIT;
            end
            CMD_SAMPLE: begin
              if (count_r >= CNT_W'(MAX_SAMPLES)) begin
                dropped_nxt = 1'b1;
              end else begin
                count_nxt     = count_r + CNT_W'(1);
                sq_mcand_nxt  = SQ_W'(in_ch.sample_code);
                sq_mplier_nxt = in_ch.sample_code;
                sq_acc_nxt    = '0;
                step_nxt      = STEP_W'(SAMPLE_BITS - 1);
                state_nxt     = ST_SQR;
              end
            end
            CMD_WINDOW: begin
              kind_nxt = KIND_MEASURE;
              if (count_r == '0) begin
                mp_acc_nxt = '0;
                state_nxt  = ST_EMIT;
              end else begin
                num_nxt   = {sum_r, {SHIFT_Q{1'b0}}};
                rem_nxt   = '0;
                step_nxt  = STEP_W'(DIV_W - 1);
                state_nxt = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SQR: begin
        if (sq_mplier_r[0]) begin
          sq_acc_nxt = sq_acc_r + sq_mcand_r;
        end
        sq_mcand_nxt  = {sq_mcand_r[SQ_W-2:0], 1'b0};
        sq_mplier_nxt = {1'b0, sq_mplier_r[SAMPLE_BITS-1:1]};
        step_nxt      = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        sum_nxt   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        // quotient bits shift into the dividend register from the bottom
        rem_nxt  = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
        num_nxt  = {num_r[DIV_W-2:0], div_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          rad_nxt   = (2*RT_W)'({num_r[DIV_W-2:0], div_ge});
          srem_nxt  = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(RT_W - 1);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        srem_nxt = sq_ge ? sq_diff[RT_W+1:0] : sq_trial[RT_W+1:0];
        root_nxt = {root_r[RT_W-2:0], sq_ge};
        rad_nxt  = {rad_r[2*RT_W-3:0], 2'b00};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          mp_mcand_nxt  = MP_W'({root_r[RT_W-2:0], sq_ge});
          mp_mplier_nxt = gain_r;
          mp_acc_nxt    = '0;
          step_nxt      = STEP_W'(GAIN_W - 1);
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mp_mplier_r[0]) begin
          mp_acc_nxt = mp_acc_r + mp_mcand_r;
        end
        mp_mcand_nxt  = {mp_mcand_r[MP_W-2:0], 1'b0};
        mp_mplier_nxt = {1'b0, mp_mplier_r[GAIN_W-1:1]};
        step_nxt      = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // wait for the result register to drain
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          o_kind_nxt = kind_r;
          o_mux_nxt  = mux_r;
          o_chan_nxt = chan_r;
          o_rms_nxt  = rms_sat;
          o_ovf_nxt  = dropped_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      gain_r    <= GAIN_RESET;
      index_r   <= 3'd0;
      mux_r     <= '0;
      chan_r    <= 1'b1;
      sum_r     <= '0;
      count_r   <= '0;
      dropped_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      gain_r    <= gain_nxt;
      index_r   <= index_nxt;
      mux_r     <= mux_nxt;
      chan_r    <= chan_nxt;
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    sq_mcand_r  <= sq_mcand_nxt;
    sq_mplier_r <= sq_mplier_nxt;
    sq_acc_r    <= sq_acc_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    rad_r       <= rad_nxt;
    srem_r      <= srem_nxt;
    root_r      <= root_nxt;
    mp_mcand_r  <= mp_mcand_nxt;
    mp_mplier_r <= mp_mplier_nxt;
    mp_acc_r    <= mp_acc_nxt;
    kind_r      <= kind_nxt;
    o_kind_r    <= o_kind_nxt;
    o_mux_r     <= o_mux_nxt;
    o_chan_r    <= o_chan_nxt;
    o_rms_r     <= o_rms_nxt;
    o_ovf_r     <= o_ovf_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = ov_r;
  assign out_ch.kind          = o_kind_r;
  assign out_ch.mux_select    = o_mux_r;
  assign out_ch.adc_channel   = o_chan_r;
  assign out_ch.rms_centiamps = o_rms_r;
  assign out_ch.overflow      = o_ovf_r;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rmscm_pkg::*;

  localparam int MAX_SAMPLES = MAX_SAMPLES_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int CODE_TOP    = (1 << SAMPLE_BITS) - 1;
  localparam int HALF_PERIOD = 5;

  // cmd 3 has no meaning to the block; it must be swallowed without a result
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [RMS_W-1:0] RMS_TOP = '1;

  // Settle time, with margin over the work of a window end in the block
  localparam int SETTLE_CYCLES = 128;
  // Long receiver hold-off used to back the block up
  localparam int HOLD_CYCLES   = 400;
  // Watchdog: cycles without any transaction on any channel
  localparam int QUIET_LIMIT   = 5000;

  typedef struct packed {
    logic             kind;
    logic [MUX_W-1:0] mux_select;
    logic             adc_channel;
    logic [RMS_W-1:0] rms_centiamps;
    logic             overflow;
  } reading_t;

  // Tracks the meter state alongside the block and checks every result
  // transaction against the oldest predicted reading.
  class rms_reading_checker;
    logic [GAIN_W-1:0] gain;
    logic [2:0]        step_idx;
    logic [MUX_W-1:0]  mux_sel;
    logic              chan_sel;
    logic [SUM_W-1:0]  sq_sum;
    int                n_samples;
    logic              dropped;
    reading_t          pending_readings[$];
    int                errors;
    int                readings_seen;
    int                measurements;
    int                flagged_windows;

    function new();
      gain            = GAIN_RESET;
      step_idx        = '0;
      mux_sel         = '0;
      chan_sel        = 1'b1;
      sq_sum          = '0;
      n_samples       = 0;
      dropped         = 1'b0;
      errors          = 0;
      readings_seen   = 0;
      measurements    = 0;
      flagged_windows = 0;
    endfunction

    // Bitwise integer square root, floor
    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] place;
      root  = '0;
      place = 64'd1 << 62;
      while (place > v)
        place = place >> 2;
      while (place != 0) begin
        if (v >= root + place) begin
          v    = v - (root + place);
          root = (root >> 1) + place;
        end else begin
          root = root >> 1;
        end
        place = place >> 2;
      end
      return root;
    endfunction

    // Q16 mean square (with the factor 2), Q8 root, times gain, >> 20
    function logic [RMS_W-1:0] window_rms();
      logic [63:0] mean_sq;
      logic [63:0] scaled;
      if (n_samples == 0)
        return '0;
      mean_sq = (64'(sq_sum) << SHIFT_Q) / 64'(n_samples);
      scaled  = (int_sqrt(mean_sq) * 64'(gain)) >> RMS_SHIFT;
      if (scaled > 64'(RMS_TOP))
        return RMS_TOP;
      return scaled[RMS_W-1:0];
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [SAMPLE_BITS-1:0] code);
      logic [SUM_W:0] code_ext;
      logic [SUM_W:0] grown;
      reading_t       r;
      case (cmd)
        CMD_REQUEST: begin
          step_idx = step_idx + 3'd1;
          if (step_idx <= LAST_INDEX) begin
            mux_sel  = 2'(step_idx - 3'd1);
            chan_sel = 1'b1;
          end else begin
            // fifth step: keep the select, switch to channel 0, wrap
            chan_sel = 1'b0;
            step_idx = '0;
          end
          sq_sum    = '0;
          n_samples = 0;
          dropped   = 1'b0;
          r = '{KIND_SETUP, mux_sel, chan_sel, '0, 1'b0};
          pending_readings.push_back(r);
        end
        CMD_SAMPLE: begin
          if (n_samples >= MAX_SAMPLES) begin
            dropped = 1'b1;
          end else begin
            code_ext = (SUM_W + 1)'(code);
            grown    = {1'b0, sq_sum} + code_ext * code_ext;
            sq_sum   = grown[SUM_W] ? '1 : grown[SUM_W-1:0];
            n_samples++;
          end
        end
        CMD_WINDOW: begin
          // sum, count and flag stay as they are
          r = '{KIND_MEASURE, mux_sel, chan_sel, window_rms(), dropped};
          pending_readings.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind=%0d mux=%0d ch=%0d rms=%0d ovf=%0d",
                 $time, got.kind, got.mux_select, got.adc_channel, got.rms_centiamps,
                 got.overflow);
        return;
      end
      want = pending_readings.pop_front();
      if (want.kind == KIND_MEASURE)
        measurements++;
      if (want.overflow)
        flagged_windows++;
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("mux_select", 32'(want.mux_select), 32'(got.mux_select));
      compare_field("adc_channel", 32'(want.adc_channel), 32'(got.adc_channel));
      compare_field("rms_centiamps", 32'(want.rms_centiamps), 32'(got.rms_centiamps));
      compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  rmscm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  rmscm_out_if                             out_ch ();
  rmscm_cfg_if                             cfg_ch ();

  rms_current_meter_channel_rotation #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rms_reading_checker readings;

  // Traffic shaping knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // Bumped by the stimulus to ask the receiver for one long hold-off
  int holds_asked    = 0;
  // Commands the block acts on (cmd 3 not counted)
  int items_sent     = 0;

  // ---------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block's
  // registers update. Result first: a result at this edge can only belong to
  // an earlier command.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    reading_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.mux_select, out_ch.adc_channel,
                out_ch.rms_centiamps, out_ch.overflow};
        readings.check_reading(got);
      end
      if (cfg_ch.valid && cfg_ch.ready)
        readings.gain = cfg_ch.gain_centiamps_fullscale;
      if (in_ch.valid && in_ch.ready)
        readings.note_command(in_ch.cmd, in_ch.sample_code);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready at the falling edge, plus an occasional long
  // hold-off counted here so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left    = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet);
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. send_command returns right after the accepting edge with valid
  // still high, so the next call (or the drain) decides at the following
  // falling edge whether valid stays up or drops: one assignment per step.
  // ---------------------------------------------------------------------------
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [SAMPLE_BITS-1:0] code);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.sample_code <= code;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    if (cmd != CMD_UNUSED)
      items_sent++;
  endtask

  // Wait for all predicted readings, then let a sample still in the squarer
  // (it causes no result) finish before anything else happens.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (readings.pending_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called with the block idle (after drain)
  task automatic write_gain(logic [GAIN_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid                    <= 1'b1;
    cfg_ch.gain_centiamps_fullscale <= value;
    @(posedge clk);
    while (!cfg_ch.ready)
      @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Converter codes: bias toward the rails
  function automatic logic [SAMPLE_BITS-1:0] random_code();
    case ($urandom_range(7))
      0:       return '0;
      1:       return SAMPLE_BITS'(CODE_TOP);
      default: return SAMPLE_BITS'($urandom_range(CODE_TOP));
    endcase
  endfunction

  // Mostly complete windows (request, a few samples, window end, sometimes a
  // repeated window end); the rest is single commands of any kind, cmd 3 too.
  task automatic run_random(int n_items);
    int stop_at;
    int n_samp;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) begin
        send_command(CMD_REQUEST, random_code());
        n_samp = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 0);
        repeat (n_samp) send_command(CMD_SAMPLE, random_code());
        send_command(CMD_WINDOW, random_code());
        if ($urandom_range(4) == 0)
          send_command(CMD_WINDOW, random_code());
      end else begin
        send_command(2'($urandom_range(3)), random_code());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    readings                        = new();
    in_ch.valid                     = 1'b0;
    in_ch.cmd                       = CMD_REQUEST;
    in_ch.sample_code               = '0;
    cfg_ch.valid                    = 1'b0;
    cfg_ch.gain_centiamps_fullscale = GAIN_RESET;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset gain, no idling
    send_command(CMD_WINDOW, '0);                       // empty window straight out of reset
    send_command(CMD_UNUSED, SAMPLE_BITS'(CODE_TOP));   // ignored, no result
    send_command(CMD_SAMPLE, SAMPLE_BITS'(CODE_TOP));   // sample before any request
    send_command(CMD_WINDOW, '0);
    send_command(CMD_REQUEST, SAMPLE_BITS'(CODE_TOP));  // code ignored on a request
    send_command(CMD_SAMPLE, '0);
    send_command(CMD_WINDOW, '0);                       // one zero sample
    send_command(CMD_SAMPLE, 12'hAAA);
    send_command(CMD_SAMPLE, 12'h555);
    send_command(CMD_WINDOW, '0);
    send_command(CMD_WINDOW, '0);                       // window end leaves state alone
    // rest of the rotation: selects 1..3, then channel 0 on the last select, wrap
    repeat (4) send_command(CMD_REQUEST, '0);
    send_command(CMD_REQUEST, '0);
    drain();

    // Gain extremes
    write_gain(16'd1);
    send_command(CMD_SAMPLE, SAMPLE_BITS'(CODE_TOP));
    send_command(CMD_WINDOW, '0);
    drain();
    write_gain('1);
    send_command(CMD_WINDOW, '0);

    // Count limit: samples past MAX_SAMPLES are dropped and flagged; the next
    // request clears the flag again
    send_command(CMD_REQUEST, '0);
    repeat (MAX_SAMPLES + 6) send_command(CMD_SAMPLE, SAMPLE_BITS'(CODE_TOP));
    send_command(CMD_WINDOW, '0);
    send_command(CMD_WINDOW, '0);
    send_command(CMD_REQUEST, '0);
    send_command(CMD_WINDOW, '0);

    // Random part: four traffic patterns, a different gain in each
    for (phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_gain(GAIN_W'($urandom_range(65535, 1)));
          // long receiver hold with the sender pushing: block must back up
          holds_asked++;
          repeat (8) begin
            send_command(CMD_REQUEST, random_code());
            send_command(CMD_WINDOW, random_code());
          end
        end
        1: begin
          send_idle_pct  = 76;
          recv_stall_pct = 0;
          write_gain(16'd1);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 76;
          write_gain('1);
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
          write_gain(GAIN_RESET);
        end
      endcase
      run_random(200);
    end

    drain();
    $display("Run covered %0d commands and %0d results (%0d measurements, %0d flagged windows),",
             items_sent, readings.readings_seen, readings.measurements,
             readings.flagged_windows);
    $display("four traffic patterns, one long receiver hold, gains from 1 to full scale.");
    if (readings.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rmscm_pkg.sv
rtl/core/rmscm_in_if.sv
rtl/core/rmscm_out_if.sv
rtl/core/rmscm_cfg_if.sv
rtl/core/rms_current_meter_channel_rotation.sv
bench/testbench.sv
